FILE: rtl/rsas_pkg.sv
// ----------------------------------------------------------------------------
// rsas_pkg
// Shared constants for the rotated sorted array search block: default sizes,
// the fixed field widths of the stream items and the opcode values.
// ----------------------------------------------------------------------------
package rsas_pkg;

  // Default sizes of the element ring
  localparam int DEFAULT_MAX_ELEMENTS = 64;
  localparam int DEFAULT_VALUE_WIDTH  = 32;

  // Fixed widths of the item fields
  localparam int FIELD_W   = 32;  // load_value and search_key
  localparam int POS_W     = 6;   // load_index, match_index, pivot_index
  localparam int COUNT_W   = 7;   // element_count register

  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

  // Item kinds carried on tuser
  localparam logic OPCODE_LOAD   = 1'b0;
  localparam logic OPCODE_SEARCH = 1'b1;

endpackage

FILE: rtl/rsas_cell.sv
// ----------------------------------------------------------------------------
// rsas_cell
// One element cell of the rotating ring. Every cycle it takes the element of
// its upper neighbor; a broadcast write lands in the cell whose position
// matches instead.
// ----------------------------------------------------------------------------
module rsas_cell #(
  parameter int VALUE_WIDTH = 32,
  parameter int INDEX_WIDTH = 6,
  parameter int CELL_INDEX  = 0
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic        [INDEX_WIDTH-1:0] wr_pos_i,
  input  logic signed [VALUE_WIDTH-1:0] wr_value_i,
  input  logic signed [VALUE_WIDTH-1:0] shift_i,
  output logic signed [VALUE_WIDTH-1:0] value_o
);

  logic signed [VALUE_WIDTH-1:0] value_q, value_d;

  // Rotate, or capture the write aimed at this cell
  always_comb begin
    if (wr_en_i && (wr_pos_i == INDEX_WIDTH'(CELL_INDEX))) begin
      value_d = wr_value_i;
    end else begin
      value_d = shift_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

FILE: rtl/rsas_ctrl.sv
// ----------------------------------------------------------------------------
// rsas_ctrl
// Sequencer of the search: keeps the ring phase, decodes load items into ring
// writes, runs the pivot search and the key search one element read at a
// time from the head cell, and holds the result register.
// ----------------------------------------------------------------------------
module rsas_ctrl
  import rsas_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEFAULT_MAX_ELEMENTS,
  parameter int VALUE_WIDTH  = DEFAULT_VALUE_WIDTH,
  parameter int IW           = $clog2(MAX_ELEMENTS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic        [POS_W-1:0]       load_index_i,
  input  logic        [FIELD_W-1:0]     load_value_i,
  input  logic        [FIELD_W-1:0]     search_key_i,
  // register write
  input  logic                          cfg_valid_i,
  input  logic        [COUNT_W-1:0]     cfg_data_i,
  // ring
  input  logic signed [VALUE_WIDTH-1:0] head_value_i,
  output logic                          wr_en_o,
  output logic        [IW-1:0]          wr_pos_o,
  output logic signed [VALUE_WIDTH-1:0] wr_value_o,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          found_o,
  output logic        [POS_W-1:0]       match_index_o,
  output logic        [POS_W-1:0]       pivot_index_o
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int LW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PIV_HI,
    S_PIV_CHK,
    S_PIV_RD,
    S_HEAD,
    S_TAIL,
    S_SRCH_CHK,
    S_SRCH_RD,
    S_EMIT
  } state_e;

  state_e                        state_q, state_d;
  logic        [IW-1:0]          ph_q, ph_d;
  logic        [COUNT_W-1:0]     count_q, count_d;
  logic        [CW-1:0]          n_q, n_d;
  logic        [CW-1:0]          lo_q, lo_d;
  logic        [CW-1:0]          hi_q, hi_d;
  logic        [IW-1:0]          addr_q, addr_d;
  logic        [IW-1:0]          piv_q, piv_d;
  logic signed [VALUE_WIDTH-1:0] ref_q, ref_d;
  logic signed [VALUE_WIDTH-1:0] head_q, head_d;
  logic signed [VALUE_WIDTH-1:0] key_q, key_d;
  logic                          hit_q, hit_d;
  logic                          out_valid_q, out_valid_d;
  logic                          found_q, found_d;
  logic        [POS_W-1:0]       match_q, match_d;
  logic        [POS_W-1:0]       pivot_q, pivot_d;

  logic                          accept;
  logic                          at_addr;
  logic        [CW:0]            mid_sum;
  logic        [IW-1:0]          mid;
  logic        [EW-1:0]          count_ext;
  logic        [CW-1:0]          n_clamp;
  logic        [LW-1:0]          idx_ext;
  logic                          idx_ok;
  logic        [IW:0]            wr_target;

  assign accept  = in_valid_i && in_ready_o;
  assign at_addr = (ph_q == addr_q);
  assign mid_sum = (CW+1)'(lo_q) + (CW+1)'(hi_q);
  assign mid     = IW'(mid_sum >> 1);

  // Active element count: zero acts as one, large counts clip to the ring size
  always_comb begin
    count_ext = EW'(count_q);
    if (count_ext == '0) begin
      n_clamp = CW'(1);
    end else if (count_ext > EW'(MAX_ELEMENTS)) begin
      n_clamp = CW'(MAX_ELEMENTS);
    end else begin
      n_clamp = CW'(count_ext);
    end
  end

  // Load decode: cell k holds element (k + phase) mod N after the next rotation
  // when k = (index - phase - 1) mod N
  always_comb begin
    idx_ext   = LW'(load_index_i);
    idx_ok    = (idx_ext < LW'(MAX_ELEMENTS));
    wr_target = (IW+1)'(IW'(load_index_i)) + (IW+1)'(MAX_ELEMENTS - 1) - (IW+1)'(ph_q);
    if (wr_target >= (IW+1)'(MAX_ELEMENTS)) begin
      wr_target = wr_target - (IW+1)'(MAX_ELEMENTS);
    end
  end

  assign wr_en_o    = accept && (opcode_i == OPCODE_LOAD) && idx_ok;
  assign wr_pos_o   = IW'(wr_target);
  assign wr_value_o = VALUE_WIDTH'($signed(load_value_i));

  // Ring phase: index of the element now in the head cell
  assign ph_d = (ph_q == IW'(MAX_ELEMENTS - 1)) ? '0 : ph_q + 1'b1;

  assign count_d = cfg_valid_i ? cfg_data_i : count_q;

  // Search sequencer
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    addr_d      = addr_q;
    piv_d       = piv_q;
    ref_d       = ref_q;
    head_d      = head_q;
    key_d       = key_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    match_d     = match_q;
    pivot_d     = pivot_q;
    in_ready_o  = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (accept && (opcode_i == OPCODE_SEARCH)) begin
          key_d   = VALUE_WIDTH'($signed(search_key_i));
          n_d     = n_clamp;
          lo_d    = '0;
          hi_d    = n_clamp - 1'b1;
          addr_d  = IW'(n_clamp - 1'b1);
          state_d = S_PIV_HI;
        end
      end
      // Reference element at the upper bound of the pivot search
      S_PIV_HI: begin
        if (at_addr) begin
          ref_d   = head_value_i;
          state_d = S_PIV_CHK;
        end
      end
      S_PIV_CHK: begin
        if (lo_q < hi_q) begin
          addr_d  = mid;
          state_d = S_PIV_RD;
        end else begin
          piv_d = IW'(lo_q);
          if (lo_q != '0) begin
            addr_d  = '0;
            state_d = S_HEAD;
          end else begin
            hi_d    = n_q;
            state_d = S_SRCH_CHK;
          end
        end
      end
      S_PIV_RD: begin
        if (at_addr) begin
          if (head_value_i > ref_q) begin
            lo_d = CW'(addr_q) + 1'b1;
          end else begin
            hi_d  = CW'(addr_q);
            ref_d = head_value_i;
          end
          state_d = S_PIV_CHK;
        end
      end
      // First element of the upper run
      S_HEAD: begin
        if (at_addr) begin
          head_d  = head_value_i;
          addr_d  = IW'(lo_q - 1'b1);
          state_d = S_TAIL;
        end
      end
      // Last element before the pivot picks the run to search
      S_TAIL: begin
        if (at_addr) begin
          if ((key_q >= head_q) && (key_q <= head_value_i)) begin
            lo_d = '0;
            hi_d = CW'(piv_q);
          end else begin
            hi_d = n_q;
          end
          state_d = S_SRCH_CHK;
        end
      end
      S_SRCH_CHK: begin
        if (lo_q < hi_q) begin
          addr_d  = mid;
          state_d = S_SRCH_RD;
        end else begin
          hit_d   = 1'b0;
          state_d = S_EMIT;
        end
      end
      S_SRCH_RD: begin
        if (at_addr) begin
          if (head_value_i == key_q) begin
            hit_d   = 1'b1;
            state_d = S_EMIT;
          end else begin
            if (key_q < head_value_i) begin
              hi_d = CW'(addr_q);
            end else begin
              lo_d = CW'(addr_q) + 1'b1;
            end
            state_d = S_SRCH_CHK;
          end
        end
      end
      // Hand the result over once the output register is free
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          found_d     = hit_q;
          match_d     = hit_q ? POS_W'(addr_q) : '0;
          pivot_d     = POS_W'(piv_q);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= '0;
      count_q     <= COUNT_RESET;
      n_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      addr_q      <= '0;
      piv_q       <= '0;
      ref_q       <= '0;
      head_q      <= '0;
      key_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      match_q     <= '0;
      pivot_q     <= '0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      count_q     <= count_d;
      n_q         <= n_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      addr_q      <= addr_d;
      piv_q       <= piv_d;
      ref_q       <= ref_d;
      head_q      <= head_d;
      key_q       <= key_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      match_q     <= match_d;
      pivot_q     <= pivot_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign match_index_o = match_q;
  assign pivot_index_o = pivot_q;

endmodule

FILE: rtl/rotated_sorted_array_search.sv
// ----------------------------------------------------------------------------
// rotated_sorted_array_search
// Top level: a ring of element cells that rotates by one place each cycle,
// and the sequencer that loads it and searches it.
// ----------------------------------------------------------------------------
// A load item gives no result. A search item runs a binary search for the
// pivot, reads the two run boundaries if the array is rotated, and runs a
// binary search for the key; every element read waits until the addressed
// element has rotated into the head cell of the ring. A search makes at most
// about 2*log2(MAX_ELEMENTS)+3 such reads, then hands over the result. One
// item is worked on at a time; the next item is taken while the previous
// result still waits in the output register. The element_count register may
// be written at any time the block is idle and is always ready.
// ----------------------------------------------------------------------------
module rotated_sorted_array_search
  import rsas_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEFAULT_MAX_ELEMENTS,
  parameter int VALUE_WIDTH  = DEFAULT_VALUE_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [71:0]           s_axis_tdata,  // load_index[5:0], load_value[37:6],
                                               // search_key[69:38], zero[71:70]
  input  logic                  s_axis_tuser,  // opcode
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,  // found[0], match_index[6:1],
                                               // pivot_index[12:7], zero[15:13]
  // element_count register
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [COUNT_W-1:0]    cfg_data_i
);

  localparam int IW = $clog2(MAX_ELEMENTS);

  logic signed [VALUE_WIDTH-1:0] ring_w [MAX_ELEMENTS];
  logic                          wr_en;
  logic        [IW-1:0]          wr_pos;
  logic signed [VALUE_WIDTH-1:0] wr_value;
  logic                          found;
  logic        [POS_W-1:0]       match_index;
  logic        [POS_W-1:0]       pivot_index;

  assign cfg_ready_o = 1'b1;

  // Ring of cells: each one takes its upper neighbor, the last takes the head
  for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
    rsas_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .INDEX_WIDTH (IW),
      .CELL_INDEX  (k)
    ) u_cell (
      .clk_i      (clk_i),
      .wr_en_i    (wr_en),
      .wr_pos_i   (wr_pos),
      .wr_value_i (wr_value),
      .shift_i    (ring_w[(k + 1) % MAX_ELEMENTS]),
      .value_o    (ring_w[k])
    );
  end

  // Sequencer
  rsas_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_WIDTH  (VALUE_WIDTH),
    .IW           (IW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .opcode_i      (s_axis_tuser),
    .load_index_i  (s_axis_tdata[5:0]),
    .load_value_i  (s_axis_tdata[37:6]),
    .search_key_i  (s_axis_tdata[69:38]),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .head_value_i  (ring_w[0]),
    .wr_en_o       (wr_en),
    .wr_pos_o      (wr_pos),
    .wr_value_o    (wr_value),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .found_o       (found),
    .match_index_o (match_index),
    .pivot_index_o (pivot_index)
  );

  assign m_axis_tdata = {3'b000, pivot_index, match_index, found};

endmodule

FILE: sim/rotated_sorted_array_search_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotated_sorted_array_search_tb
// Loads rotated ascending arrays into the element store, then searches them.
// Every search result is compared field by field against a behavioral
// predictor. Covers the count extremes, arrays that are not rotated, absent
// keys, unordered and repeated contents, and random stalls on both streams.
// ----------------------------------------------------------------------------
module rotated_sorted_array_search_tb;
  import rsas_pkg::*;

  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_index;
    logic [POS_W-1:0] pivot_index;
  } search_result_t;

  localparam int VALUE_MIN = 32'h8000_0000;
  localparam int VALUE_MAX = 32'h7FFF_FFFF;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [71:0]        s_axis_tdata  = '0;  // load_index, load_value, search_key, zero
  logic               s_axis_tuser  = 1'b0;  // opcode
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;  // found, match_index, pivot_index, zero
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [COUNT_W-1:0] cfg_data_i    = '0;

  // Predictor state: store contents and count as the block should hold them
  int             element_model [DEFAULT_MAX_ELEMENTS];
  count_t         model_count = COUNT_RESET;
  search_result_t pending_results [$];

  int error_count       = 0;
  int items_sent        = 0;
  bit send_burst        = 1'b0;
  bit sink_burst        = 1'b0;
  int sink_hold_request = 0;

  rotated_sorted_array_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Effective number of entries taking part in a search
  function automatic int active_count(input count_t c);
    if (c == 0) return 1;
    if (c > DEFAULT_MAX_ELEMENTS) return DEFAULT_MAX_ELEMENTS;
    return int'(c);
  endfunction

  // Pivot by binary search, then binary search of the run that can hold the key
  function automatic search_result_t predict_search(input int key);
    int n, lo, hi, mid, pivot;
    search_result_t res;
    n  = active_count(model_count);
    lo = 0;
    hi = n - 1;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (element_model[mid] > element_model[hi]) lo = mid + 1;
      else hi = mid;
    end
    pivot = lo;
    if (pivot > 0 && key >= element_model[0] && key <= element_model[pivot-1]) begin
      lo = 0;
      hi = pivot;
    end else begin
      lo = pivot;
      hi = n;
    end
    res.found       = 1'b0;
    res.match_index = '0;
    res.pivot_index = POS_W'(pivot);
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (element_model[mid] == key) begin
        res.found       = 1'b1;
        res.match_index = POS_W'(mid);
        break;
      end
      if (key < element_model[mid]) hi = mid;
      else lo = mid + 1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  // Offer one item; on acceptance update the store copy or queue the expected result
  task automatic send_item(input logic op, input logic [POS_W-1:0] idx,
                           input logic [31:0] value, input logic [31:0] key);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, key, value, idx};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    items_sent++;
    if (op == OPCODE_LOAD) element_model[idx] = int'(value);
    else pending_results.push_back(predict_search(int'(key)));
  endtask

  task automatic load_element(input int idx, input int value);
    send_item(OPCODE_LOAD, POS_W'(idx), value, $urandom);
  endtask

  task automatic search_for(input int key);
    send_item(OPCODE_SEARCH, POS_W'($urandom), $urandom, key);
  endtask

  // Drop valid, drain all results, then give the last load time to finish
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_count(input count_t value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    model_count = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Compare one result item against the oldest expectation
  task automatic check_result(input logic [15:0] word);
    search_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with no search pending", word, '0);
      return;
    end
    want = pending_results.pop_front();
    if (word[0] !== want.found) report_mismatch("found", word[0], want.found);
    if (word[6:1] !== want.match_index)
      report_mismatch("match_index", word[6:1], want.match_index);
    if (word[12:7] !== want.pivot_index)
      report_mismatch("pivot_index", word[12:7], want.pivot_index);
  endtask

  // Result sink: random wait per item, plus a long hold-off on request
  initial begin : result_sink
    int hold;
    @(posedge rst_ni);
    forever begin
      hold = sink_burst ? 0 : $urandom_range(0, 18);
      if (sink_hold_request > 0) begin
        hold = sink_hold_request;
        sink_hold_request = 0;
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      check_result(m_axis_tdata);
    end
  end

  // One array: optional count write, a full load in random order, then searches
  task automatic run_phase(input bit write_cfg, input count_t count_value);
    int n, kind, rot, nsearch, pick, base, j, tmp;
    int vals [$];
    int slots [DEFAULT_MAX_ELEMENTS];
    int arr [DEFAULT_MAX_ELEMENTS];
    send_burst = ($urandom_range(0, 3) == 0);
    sink_burst = ($urandom_range(0, 3) == 0);
    if (write_cfg) begin
      wait_idle();
      write_count(count_value);
    end
    n    = active_count(model_count);
    kind = $urandom_range(0, 9);
    base = $urandom;
    // kind 0: unordered, 1: many repeats, 2: dense range, else full range
    for (int i = 0; i < n; i++) begin
      case (kind)
        0: vals.push_back($urandom);
        1: vals.push_back(base + $urandom_range(0, 3));
        2: vals.push_back(base + i * $urandom_range(1, 4));
        default: vals.push_back($urandom);
      endcase
    end
    if (kind != 0) vals.sort();
    if (kind >= 3 && $urandom_range(0, 3) == 0) begin
      vals[0]   = VALUE_MIN;
      vals[n-1] = VALUE_MAX;
    end
    rot = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      arr[i]   = vals[(i + rot) % n];
      slots[i] = i;
    end
    for (int i = n - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = slots[i];
      slots[i] = slots[j];
      slots[j] = tmp;
    end
    // Load, with the odd stray write past the active range
    for (int i = 0; i < n; i++) begin
      if (n < DEFAULT_MAX_ELEMENTS && $urandom_range(0, 7) == 0)
        load_element($urandom_range(n, DEFAULT_MAX_ELEMENTS - 1), $urandom);
      load_element(slots[i], arr[slots[i]]);
    end
    nsearch = $urandom_range(3, 12);
    for (int s = 0; s < nsearch; s++) begin
      // occasionally corrupt an entry between searches
      if ($urandom_range(0, 19) == 0) load_element($urandom_range(0, n - 1), $urandom);
      pick = $urandom_range(0, 19);
      if (pick <= 11) search_for(element_model[$urandom_range(0, n - 1)]);
      else if (pick <= 14) search_for(element_model[$urandom_range(0, n - 1)] + 1);
      else if (pick <= 16) search_for(element_model[$urandom_range(0, n - 1)] - 1);
      else if (pick == 17) search_for(VALUE_MIN);
      else if (pick == 18) search_for(VALUE_MAX);
      else search_for($urandom);
    end
  endtask

  // Full 64-entry array searched with the count left at its reset value
  task automatic test_default_count();
    run_phase(1'b0, '0);
  endtask

  // Count 0 acts as a single element
  task automatic test_single_element();
    wait_idle();
    send_burst = 1'b0;
    sink_burst = 1'b0;
    write_count('0);
    load_element(0, VALUE_MIN);
    search_for(VALUE_MIN);
    search_for(VALUE_MAX);
    search_for(0);
    load_element(DEFAULT_MAX_ELEMENTS - 1, 32'hFFFF_FFFF);
    load_element(0, VALUE_MAX);
    search_for(VALUE_MAX);
    search_for(VALUE_MIN);
  endtask

  // Ascending array with no rotation: pivot stays at 0
  task automatic test_not_rotated();
    wait_idle();
    write_count(count_t'(4));
    load_element(0, -5);
    load_element(1, 0);
    load_element(2, 7);
    load_element(3, VALUE_MAX);
    search_for(7);
    search_for(-5);
    search_for(3);
    search_for(VALUE_MAX);
    search_for(VALUE_MIN);
  endtask

  // Rotated array: keys in the left run, the right run, and absent
  task automatic test_rotated();
    wait_idle();
    write_count(count_t'(5));
    load_element(0, 10);
    load_element(1, 20);
    load_element(2, -30);
    load_element(3, -20);
    load_element(4, 0);
    search_for(20);
    search_for(-20);
    search_for(10);
    search_for(0);
    search_for(15);
    search_for(-30);
  endtask

  // Sink holds off while searches keep coming, so the input stalls
  task automatic test_backpressure();
    wait_idle();
    send_burst = 1'b1;
    sink_burst = 1'b1;
    sink_hold_request = 2000;
    for (int i = 0; i < 8; i++) search_for(element_model[i % 5] + (i % 2));
    send_burst = 1'b0;
    sink_burst = 1'b0;
  endtask

  // Random arrays and counts, small sizes mostly, extremes included
  task automatic test_random_arrays();
    count_t c;
    int pick;
    while (items_sent < 650) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) c = count_t'($urandom_range(1, 12));
      else if (pick == 6) c = count_t'($urandom_range(13, 63));
      else if (pick == 7) c = count_t'(DEFAULT_MAX_ELEMENTS);
      else if (pick == 8) c = count_t'($urandom_range(65, 127));
      else begin
        case ($urandom_range(0, 2))
          0: c = '0;
          1: c = count_t'(1);
          default: c = '1;
        endcase
      end
      run_phase(1'b1, c);
    end
  endtask

  // Test sequence
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_count();
    test_single_element();
    test_not_rotated();
    test_rotated();
    test_backpressure();
    test_random_arrays();
    wait_idle();
    repeat (80) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(50_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rsas_pkg.sv
rtl/rsas_cell.sv
rtl/rsas_ctrl.sv
rtl/rotated_sorted_array_search.sv
sim/rotated_sorted_array_search_tb.sv
